@@ sv/wsb_pkg.sv @@
// shared types and constants for the workgroup start barrier
package wsb_pkg;

   localparam int TASK_ID_W = 5;
   localparam int MASK_W = 32;
   localparam int PEND_W = 6;

   typedef logic [2:0] cmd_type;
   typedef logic [TASK_ID_W-1:0] task_id_type;
   typedef logic [MASK_W-1:0] mask_type;
   typedef logic [PEND_W-1:0] pend_type;

   localparam cmd_type CMD_INIT = 3'd0;
   localparam cmd_type CMD_CREATE = 3'd1;
   localparam cmd_type CMD_FINISH = 3'd2;
   localparam cmd_type CMD_JOIN = 3'd3;
   localparam cmd_type CMD_RESUME = 3'd4;
   localparam cmd_type CMD_OTHER = 3'd5;

   localparam pend_type PENDING_MAX = 6'd63;

endpackage

@@ sv/workgroup_start_barrier_top.sv @@
// start barrier for a workgroup: tracks started and waiting tasks, filters candidate masks
//
// usage:
//  - req_ channel carries one task event word (command, task id, create flags and the
//    scheduler's candidate mask); rsp_ channel returns one word per event with the
//    filtered ready mask, checkpoint and blocking flags and the waiting mask after it
//  - a word is taken when valid is high and stall is low on that channel
//  - an event lands in the input register at its accepting edge; the barrier state
//    update and the result register load then happen together in one pass
//  - throughput is one event per cycle unless rsp_stall holds; state updates loop over
//    the masks and the pending counter, so back-to-back events see each other's effect
//  - when rsp_stall holds, the result word stays put and one more event can wait in
//    the input register; req_stall rises only once both registers are full
//  - csr_wr_en loads the start policy and clears started, waiting, pending and main
//    state; write it only while no event is in flight
//  - reset empties both registers and clears all state with the sequential policy
module workgroup_start_barrier_top #(
   parameter int TASKS = 32,
   parameter int MAIN_TASK = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wsb_pkg::cmd_type      req_command,
   input  wsb_pkg::task_id_type  req_task_id,
   input  logic                  req_after_ingress,
   input  logic                  req_create_ok,
   input  wsb_pkg::mask_type     req_candidate_mask,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wsb_pkg::mask_type     rsp_ready_mask,
   output logic                  rsp_checkpoint,
   output logic                  rsp_blocking,
   output wsb_pkg::mask_type     rsp_waiting_view
);
   import wsb_pkg::*;

   // input register
   logic        in_valid_ff;
   cmd_type     in_cmd_ff;
   task_id_type in_id_ff;
   logic        in_after_ff;
   logic        in_ok_ff;
   mask_type    in_cand_ff;

   // result register
   logic     out_valid_ff;
   mask_type out_ready_ff;
   logic     out_chpt_ff;
   logic     out_block_ff;
   mask_type out_wait_ff;

   // barrier state
   logic     phase_ff, phase_in;
   logic     main_seen_ff, main_seen_in;
   pend_type pend_ff, pend_in;
   mask_type started_ff, started_in;
   mask_type waiting_ff, waiting_in;

   mask_type ready_in;
   logic     chpt_in;
   logic     block_in;
   mask_type bit_sel;
   logic     out_load;
   logic     in_load;
   logic     step;

   assign out_load = !out_valid_ff || !rsp_stall;
   assign in_load = !in_valid_ff || out_load;
   assign step = in_valid_ff && out_load;
   assign req_stall = !in_load;

   assign bit_sel = (int'(in_id_ff) < TASKS) ? (mask_type'(1) << in_id_ff) : '0;

   always_comb begin
      phase_in = phase_ff;
      main_seen_in = main_seen_ff;
      pend_in = pend_ff;
      started_in = started_ff;
      waiting_in = waiting_ff;
      ready_in = in_cand_ff;
      chpt_in = 1'b0;
      block_in = 1'b0;
      if (in_cmd_ff == CMD_RESUME) begin
         waiting_in = waiting_ff & ~bit_sel;
      end else if (phase_ff || waiting_ff != '0) begin
         unique case (in_cmd_ff)
            CMD_INIT: begin
               if (phase_ff) begin
                  if (int'(in_id_ff) == MAIN_TASK && !main_seen_ff) begin
                     main_seen_in = 1'b1;
                     started_in = started_ff | bit_sel;
                  end else if (pend_ff != '0) begin
                     started_in = started_ff | bit_sel;
                     pend_in = pend_ff - 6'd1;
                  end
               end
            end
            CMD_CREATE: begin
               if (phase_ff && in_after_ff && in_ok_ff && (started_ff & bit_sel) != '0 &&
                   pend_ff < PENDING_MAX) begin
                  pend_in = pend_ff + 6'd1;
               end
            end
            CMD_FINISH: begin
               started_in = started_ff & ~bit_sel;
               waiting_in = waiting_ff & ~bit_sel;
               if (phase_ff && started_in == '0 && pend_ff == '0) begin
                  phase_in = 1'b0;
                  main_seen_in = 1'b0;
                  pend_in = '0;
                  started_in = '0;
               end
            end
            CMD_JOIN: begin
               if (phase_ff) begin
                  waiting_in = waiting_ff | bit_sel;
                  started_in = started_ff & ~bit_sel;
                  if (started_in == '0 && pend_ff == '0) begin
                     phase_in = 1'b0;
                     main_seen_in = 1'b0;
                     pend_in = '0;
                     started_in = '0;
                  end
                  chpt_in = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // filter uses the state after this event
         if (phase_in && waiting_in != '0) begin
            ready_in = in_cand_ff & ~waiting_in;
         end else if (waiting_in != '0) begin
            ready_in = waiting_in;
         end

         if (in_cmd_ff == CMD_JOIN && phase_in && (waiting_in & bit_sel) != '0) begin
            block_in = 1'b1;
            chpt_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
         main_seen_ff <= 1'b0;
         pend_ff <= '0;
         started_ff <= '0;
         waiting_ff <= '0;
      end else begin
         if (in_load) begin
            in_valid_ff <= req_valid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_wr_en) begin
            phase_ff <= csr_wr_data;
            main_seen_ff <= 1'b0;
            pend_ff <= '0;
            started_ff <= '0;
            waiting_ff <= '0;
         end else if (step) begin
            phase_ff <= phase_in;
            main_seen_ff <= main_seen_in;
            pend_ff <= pend_in;
            started_ff <= started_in;
            waiting_ff <= waiting_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_valid) begin
         in_cmd_ff <= req_command;
         in_id_ff <= req_task_id;
         in_after_ff <= req_after_ingress;
         in_ok_ff <= req_create_ok;
         in_cand_ff <= req_candidate_mask;
      end
      if (step) begin
         out_ready_ff <= ready_in;
         out_chpt_ff <= chpt_in;
         out_block_ff <= block_in;
         out_wait_ff <= waiting_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_ready_mask = out_ready_ff;
   assign rsp_checkpoint = out_chpt_ff;
   assign rsp_blocking = out_block_ff;
   assign rsp_waiting_view = out_wait_ff;

endmodule

@@ sv/wsb_checker.sv @@
// port-level checks for the workgroup start barrier, bound to the top level
module wsb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 csr_wr_en,
   input logic                 csr_wr_data,
   input logic                 req_valid,
   input logic                 req_stall,
   input wsb_pkg::cmd_type     req_command,
   input wsb_pkg::task_id_type req_task_id,
   input logic                 req_after_ingress,
   input logic                 req_create_ok,
   input wsb_pkg::mask_type    req_candidate_mask,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input wsb_pkg::mask_type    rsp_ready_mask,
   input logic                 rsp_checkpoint,
   input logic                 rsp_blocking,
   input wsb_pkg::mask_type    rsp_waiting_view
);
   import wsb_pkg::*;

   // a stalled result word holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ready_mask) &&
      $stable(rsp_waiting_view) && $stable(rsp_checkpoint) && $stable(rsp_blocking))
      else $error("result word changed while stalled");

   // a blocked join is always a checkpoint and leaves someone waiting
   a_block_chpt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blocking |-> rsp_checkpoint && rsp_waiting_view != '0)
      else $error("blocking without checkpoint or waiting task");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("words present after reset");

   // input side can only stall when the result side is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with free result register");

endmodule

bind workgroup_start_barrier_top wsb_checker u_wsb_checker (.*);
